// ===== hdl/lpg_pkg.sv =====
// package for the line pixel generator: widths, codes and item types
`timescale 1ns / 1ps

package lpg_pkg;

	// coordinate and address widths
	localparam int COORD_BITS     = 8;
	localparam int ADDR_BITS      = 14;
	localparam int ROW_BYTES_BITS = 6;
	localparam int MASK_BITS      = 8;

	// row bytes after reset
	localparam logic [ROW_BYTES_BITS-1:0] ROW_BYTES_RESET = ROW_BYTES_BITS'(30);

	// mask seed and pixel-in-byte select
	localparam logic [MASK_BITS-1:0] MASK_SEED = 8'h80;
	localparam int                   BIT_SEL_BITS = 3;

	// function codes of an input item
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	// input item
	typedef struct packed {
		logic                  func;
		logic [COORD_BITS-1:0] from_x;
		logic [COORD_BITS-1:0] from_y;
		logic [COORD_BITS-1:0] to_x;
		logic [COORD_BITS-1:0] to_y;
		logic                  pen;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [COORD_BITS-1:0] pix_x;
		logic [COORD_BITS-1:0] pix_y;
		logic [ADDR_BITS-1:0]  byte_addr;
		logic [MASK_BITS-1:0]  bit_mask;
		logic                  pen_out;
		logic                  last;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic start_zero;
		logic step_last;
	} dp_status_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LINE = 2'b10
	} lpg_state_t;

endpackage

// ===== hdl/lpg_ctrl.sv =====
// controller for the line pixel generator: line state, handshakes, commands
`timescale 1ns / 1ps

module lpg_ctrl
	import lpg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_func,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output dp_cmd_t    cmd,
	input  dp_status_t status,
	output logic       line_active
);

	lpg_state_t state_q;
	lpg_state_t state_next;
	logic       out_valid_q;
	logic       accept;
	logic       emit;

	// take a new item whenever the output register is free or being drained
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// commands: a start always loads, a step moves only inside a line
	always_comb begin
		cmd.load = accept & (in_func == FUNC_START);
		cmd.step = accept & (in_func == FUNC_STEP) & (state_q == ST_LINE);
	end
	assign emit = cmd.load | cmd.step;

	// line state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load && !status.start_zero) state_next = ST_LINE;
			end
			ST_LINE: begin
				if (cmd.load) begin
					state_next = status.start_zero ? ST_IDLE : ST_LINE;
				end else if (cmd.step && status.step_last) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign line_active = (state_q == ST_LINE);

endmodule

// ===== hdl/lpg_datapath.sv =====
// datapath for the line pixel generator: spans, incremental remainder, pixel and address
`timescale 1ns / 1ps

module lpg_datapath
	import lpg_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [ROW_BYTES_BITS-1:0] cfg_wr_data,
	input  in_item_t                  in_item,
	input  dp_cmd_t                   cmd,
	output dp_status_t                status,
	output out_item_t                 out_item
);

	logic [ROW_BYTES_BITS-1:0] row_bytes_q;

	// line geometry
	logic [COORD_BITS-1:0] origin_x_q, origin_y_q;
	logic                  up_x_q, up_y_q, x_major_q;
	logic [COORD_BITS-1:0] major_q, minor_q;
	logic [COORD_BITS-1:0] idx_q, off_q, rem_q;
	logic                  pen_q;

	// current pixel
	logic [COORD_BITS-1:0] pix_x_q, pix_y_q;
	logic                  last_q;

	// start-side spans
	logic [COORD_BITS-1:0] dx, dy, start_major, start_minor;
	logic                  start_x_major;

	// step-side arithmetic
	logic [COORD_BITS-1:0] idx_next, off_next, rem_next;
	logic [COORD_BITS:0]   rem_sum;
	logic                  carry;
	logic [COORD_BITS-1:0] maj_pos, min_pos;

	// spans of the new line
	always_comb begin
		dx = (in_item.to_x >= in_item.from_x) ? in_item.to_x - in_item.from_x
		                                      : in_item.from_x - in_item.to_x;
		dy = (in_item.to_y >= in_item.from_y) ? in_item.to_y - in_item.from_y
		                                      : in_item.from_y - in_item.to_y;
		start_x_major = (dx >= dy);
		start_major   = start_x_major ? dx : dy;
		start_minor   = start_x_major ? dy : dx;
	end

	// remainder walk: offset goes up once the remainder reaches the major span
	always_comb begin
		idx_next = idx_q + COORD_BITS'(1);
		rem_sum  = {1'b0, rem_q} + {1'b0, minor_q};
		carry    = (rem_sum >= {1'b0, major_q});
		rem_next = carry ? COORD_BITS'(rem_sum - {1'b0, major_q}) : rem_q + minor_q;
		off_next = carry ? off_q + COORD_BITS'(1) : off_q;
	end

	// next pixel on both axes, moving toward the end point
	always_comb begin
		if (x_major_q) begin
			maj_pos = up_x_q ? origin_x_q + idx_next : origin_x_q - idx_next;
			min_pos = up_y_q ? origin_y_q + off_next : origin_y_q - off_next;
		end else begin
			maj_pos = up_y_q ? origin_y_q + idx_next : origin_y_q - idx_next;
			min_pos = up_x_q ? origin_x_q + off_next : origin_x_q - off_next;
		end
	end

	always_comb begin
		status.start_zero = (start_major == '0);
		status.step_last  = (idx_next == major_q);
	end

	// row bytes register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= ROW_BYTES_RESET;
		end else if (cfg_wr_en) begin
			row_bytes_q <= cfg_wr_data;
		end
	end

	// line registers and output pixel
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			origin_x_q <= in_item.from_x;
			origin_y_q <= in_item.from_y;
			up_x_q     <= (in_item.to_x > in_item.from_x);
			up_y_q     <= (in_item.to_y > in_item.from_y);
			x_major_q  <= start_x_major;
			major_q    <= start_major;
			minor_q    <= start_minor;
			idx_q      <= '0;
			off_q      <= '0;
			rem_q      <= start_major >> 1;
			pen_q      <= in_item.pen;
			pix_x_q    <= in_item.from_x;
			pix_y_q    <= in_item.from_y;
			last_q     <= (start_major == '0);
		end else if (cmd.step) begin
			idx_q   <= idx_next;
			off_q   <= off_next;
			rem_q   <= rem_next;
			pix_x_q <= x_major_q ? maj_pos : min_pos;
			pix_y_q <= x_major_q ? min_pos : maj_pos;
			last_q  <= (idx_next == major_q);
		end
	end

	// address and mask of the held pixel
	always_comb begin
		out_item.pix_x     = pix_x_q;
		out_item.pix_y     = pix_y_q;
		out_item.byte_addr = ADDR_BITS'(pix_y_q) * ADDR_BITS'(row_bytes_q)
		                   + ADDR_BITS'(pix_x_q >> BIT_SEL_BITS);
		out_item.bit_mask  = MASK_SEED >> pix_x_q[BIT_SEL_BITS-1:0];
		out_item.pen_out   = pen_q;
		out_item.last      = last_q;
	end

endmodule

// ===== hdl/line_pixel_generator.sv =====
// top level of the line pixel generator
//
//  port group    dir  handshake            payload
//  in_*          in   in_valid / in_stall  in_item (start or step)
//  out_*         out  out_valid/out_stall  out_item (one pixel)
//  cfg_*         in   cfg_wr_en            cfg_wr_data (row bytes)
//
// one item per cycle: a pixel is computed in the cycle its item is accepted
// and lands in the output register; the remainder walk adds once per pixel.
// the next item is taken while the output register is free or being drained.
// reset clears the line state, the output valid and sets row bytes to 30.
// a stall on the output holds the pixel and stalls the input in turn.
`timescale 1ns / 1ps

module line_pixel_generator
	import lpg_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  in_item_t                  in_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output out_item_t                 out_item,
	input  logic                      cfg_wr_en,
	input  logic [ROW_BYTES_BITS-1:0] cfg_wr_data
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       line_active;

	// controller
	lpg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_func     (in_item.func),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.status      (status),
		.line_active (line_active)
	);

	// datapath
	lpg_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_item     (in_item),
		.cmd         (cmd),
		.status      (status),
		.out_item    (out_item)
	);

`ifndef SYNTHESIS
	// a start item shows its start pixel in the next cycle
	a_start_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load) |=> (out_valid && out_item.pix_x == $past(in_item.from_x)
			&& out_item.pix_y == $past(in_item.from_y)))
		else $error("start pixel not presented");

	// a step only moves an active line
	a_step_active: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step) |-> line_active)
		else $error("step command outside a line");

	// the last pixel of a step ends the line
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && status.step_last) |=> (!line_active && out_item.last))
		else $error("line still active after its last pixel");

	// mask has a single bit set
	a_mask_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(out_item.bit_mask))
		else $error("bit mask not one-hot");
`endif

endmodule

// ===== sim/tb_line_pixel_generator.sv =====
// testbench for the line pixel generator: directed and random lines checked pixel by pixel
`timescale 1ns / 1ps

module tb_line_pixel_generator;
	import lpg_pkg::*;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_stall;
	in_item_t                  in_item     = '0;
	logic                      out_valid;
	logic                      out_stall   = 1'b0;
	out_item_t                 out_item;
	logic                      cfg_wr_en   = 1'b0;
	logic [ROW_BYTES_BITS-1:0] cfg_wr_data = '0;

	// items waiting to be driven and pixels waiting to come out
	in_item_t  pending_items[$];
	out_item_t due_pixels[$];
	int        mismatches  = 0;
	int        cycle_count = 0;
	logic      quiet;

	// line state of the pixel model
	logic                      line_on    = 1'b0;
	logic [COORD_BITS-1:0]     pos_x      = '0;
	logic [COORD_BITS-1:0]     pos_y      = '0;
	logic [COORD_BITS-1:0]     org_x      = '0;
	logic [COORD_BITS-1:0]     org_y      = '0;
	logic [COORD_BITS-1:0]     end_x      = '0;
	logic [COORD_BITS-1:0]     end_y      = '0;
	logic [COORD_BITS-1:0]     walk_i     = '0;
	logic [COORD_BITS-1:0]     long_span  = '0;
	logic [COORD_BITS-1:0]     short_span = '0;
	logic                      pen_lvl    = 1'b0;
	logic [ROW_BYTES_BITS-1:0] row_bytes  = ROW_BYTES_RESET;

	line_pixel_generator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// no idling on either side in this window
	assign quiet = (cycle_count >= 300) && (cycle_count < 600);

	function automatic logic [COORD_BITS-1:0] span(input logic [COORD_BITS-1:0] a,
			input logic [COORD_BITS-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic logic [COORD_BITS-1:0] toward(input logic [COORD_BITS-1:0] base,
			input logic [COORD_BITS-1:0] goal, input logic [COORD_BITS-1:0] amount);
		return (goal > base) ? base + amount : base - amount;
	endfunction

	// pixel at the current position with its ram address and mask
	function automatic out_item_t pixel_at(input logic is_last);
		out_item_t   px;
		int unsigned addr;
		addr         = pos_y * row_bytes + (pos_x >> 3);
		px.pix_x     = pos_x;
		px.pix_y     = pos_y;
		px.byte_addr = addr[ADDR_BITS-1:0];
		px.bit_mask  = MASK_SEED >> pos_x[BIT_SEL_BITS-1:0];
		px.pen_out   = pen_lvl;
		px.last      = is_last;
		return px;
	endfunction

	// advance the line model by one item, returns 1 when a pixel comes out
	function automatic bit next_pixel(input in_item_t it, output out_item_t px);
		logic [COORD_BITS-1:0] dx;
		logic [COORD_BITS-1:0] dy;
		int unsigned           offset;
		px = '0;
		if (it.func == FUNC_START) begin
			org_x      = it.from_x;
			org_y      = it.from_y;
			end_x      = it.to_x;
			end_y      = it.to_y;
			pen_lvl    = it.pen;
			dx         = span(end_x, org_x);
			dy         = span(end_y, org_y);
			long_span  = (dx >= dy) ? dx : dy;
			short_span = (dx >= dy) ? dy : dx;
			walk_i     = '0;
			pos_x      = org_x;
			pos_y      = org_y;
			line_on    = (long_span != 0);
			px         = pixel_at(long_span == 0);
			return 1'b1;
		end
		if (!line_on || long_span == 0)
			return 1'b0;
		dx     = span(end_x, org_x);
		dy     = span(end_y, org_y);
		walk_i = walk_i + 1'b1;
		offset = (short_span * walk_i + (long_span >> 1)) / long_span;
		if (dx >= dy) begin
			pos_x = toward(org_x, end_x, walk_i);
			pos_y = toward(org_y, end_y, offset[COORD_BITS-1:0]);
		end else begin
			pos_y = toward(org_y, end_y, walk_i);
			pos_x = toward(org_x, end_x, offset[COORD_BITS-1:0]);
		end
		if (walk_i >= long_span)
			line_on = 1'b0;
		px = pixel_at(walk_i >= long_span);
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void add_start(input int fx, input int fy, input int tx, input int ty,
			input bit pen);
		in_item_t it;
		it.func   = FUNC_START;
		it.from_x = COORD_BITS'(fx);
		it.from_y = COORD_BITS'(fy);
		it.to_x   = COORD_BITS'(tx);
		it.to_y   = COORD_BITS'(ty);
		it.pen    = pen;
		pending_items.push_back(it);
	endfunction

	// step items carry random coordinates that the block must ignore
	function automatic void add_steps(input int n);
		in_item_t it;
		repeat (n) begin
			it.func   = FUNC_STEP;
			it.from_x = COORD_BITS'($urandom_range(255));
			it.from_y = COORD_BITS'($urandom_range(255));
			it.to_x   = COORD_BITS'($urandom_range(255));
			it.to_y   = COORD_BITS'($urandom_range(255));
			it.pen    = 1'($urandom_range(1));
			pending_items.push_back(it);
		end
	endfunction

	// mostly short whole lines, some cut off by a new start, some overrun while idle
	function automatic void add_random_lines(input int goal);
		int made;
		int r;
		int fx, fy, tx, ty;
		int lim, big, sml, ddx, ddy, len, n;
		made = 0;
		while (made < goal) begin
			r  = $urandom_range(99);
			fx = $urandom_range(255);
			fy = $urandom_range(255);
			if (r < 5) begin
				tx = fx;
				ty = fy;
			end else if (r < 95) begin
				lim = (r < 80) ? 10 : 60;
				big = $urandom_range(lim, 1);
				sml = ($urandom_range(9) == 0) ? big : $urandom_range(big, 0);
				if ($urandom_range(1)) begin
					ddx = big;
					ddy = sml;
				end else begin
					ddx = sml;
					ddy = big;
				end
				tx = (fx < ddx || ($urandom_range(1) && fx + ddx <= 255)) ? fx + ddx : fx - ddx;
				ty = (fy < ddy || ($urandom_range(1) && fy + ddy <= 255)) ? fy + ddy : fy - ddy;
			end else begin
				tx = $urandom_range(255);
				ty = $urandom_range(255);
			end
			ddx = (tx >= fx) ? tx - fx : fx - tx;
			ddy = (ty >= fy) ? ty - fy : fy - ty;
			len = (ddx >= ddy) ? ddx : ddy;
			add_start(fx, fy, tx, ty, 1'($urandom_range(1)));
			r = $urandom_range(9);
			n = (r == 0 && len > 0) ? $urandom_range(len - 1, 0) : len;
			add_steps(n);
			made += 1 + n;
			if (r == 1)
				add_steps($urandom_range(3, 1));
		end
	endfunction

	// hold off until every item is taken and every pixel has arrived
	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || due_pixels.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_row_bytes(input logic [ROW_BYTES_BITS-1:0] value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		row_bytes   = value;
	endtask

	// driver: present pending items, predict each one as it is accepted
	always @(posedge clk) begin
		out_item_t px;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (next_pixel(in_item, px))
					due_pixels.push_back(px);
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 14)) begin
					in_valid <= 1'b1;
					in_item  <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each accepted pixel with the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_pixels.size() == 0) begin
					$display("%0t: unexpected item, expected none, got %h", $time, out_item);
					mismatches++;
				end else begin
					want = due_pixels.pop_front();
					check_field("pix_x", want.pix_x, out_item.pix_x);
					check_field("pix_y", want.pix_y, out_item.pix_y);
					check_field("byte_addr", want.byte_addr, out_item.byte_addr);
					check_field("bit_mask", want.bit_mask, out_item.bit_mask);
					check_field("pen_out", want.pen_out, out_item.pen_out);
					check_field("last", want.last, out_item.last);
				end
			end
			out_stall <= !quiet && ($urandom_range(99) < 14);
		end
	end

	// stimulus
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed lines at the reset row width
		add_steps(1);
		add_start(0, 0, 0, 0, 1'b1);
		add_steps(1);
		add_start(0, 0, 255, 255, 1'b1);
		add_steps(2);
		add_start(255, 255, 0, 0, 1'b0);
		add_steps(2);
		add_start(255, 0, 0, 3, 1'b1);
		add_steps(1);
		add_start(7, 250, 9, 0, 1'b0);
		add_steps(2);
		add_start(200, 100, 203, 97, 1'b1);
		add_steps(4);
		add_start(255, 255, 255, 255, 1'b0);

		// random lines over several row widths, extremes included
		set_row_bytes(6'd63);
		add_random_lines(200);
		set_row_bytes(6'd0);
		add_random_lines(150);
		set_row_bytes(6'd1);
		add_random_lines(150);
		set_row_bytes(ROW_BYTES_BITS'($urandom_range(62, 2)));
		add_random_lines(225);
		set_row_bytes(ROW_BYTES_BITS'($urandom_range(62, 2)));
		add_random_lines(225);

		wait_idle();
		if (mismatches == 0)
			$display("tb_line_pixel_generator passed");
		else
			$display("tb_line_pixel_generator failed");
		$finish;
	end

	// run limit
	initial begin
		#400000;
		$display("tb_line_pixel_generator failed");
		$finish;
	end

endmodule
